### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default queue depth
  localparam int DEPTH_DEF   = 16;
  localparam int KEY_W       = 32;
  localparam int HANDLE_W    = 16;
  localparam int REQ_W       = 2;
  localparam int COUNT_OUT_W = 5;

  // request codes; the two unused codes behave as a status request
  typedef logic [REQ_W-1:0] req_t;
  localparam req_t REQ_ENQ = 2'd0;
  localparam req_t REQ_DEQ = 2'd1;

  // one stored entry as held by a cell
  typedef struct packed {
    logic                       valid;
    logic signed [KEY_W-1:0]    key;
    logic        [HANDLE_W-1:0] handle;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } op_t;

endpackage

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares its key against the broadcast key
// and either holds, takes the new word, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  spq_pkg::op_t    op,
  input  spq_pkg::entry_t new_word,
  input  spq_pkg::entry_t left_word,
  input  logic            left_ins,
  input  spq_pkg::entry_t right_word,
  output spq_pkg::entry_t word,
  output logic            ins
);
  import spq_pkg::*;

  logic                       valid_r, valid_nxt;
  logic signed [KEY_W-1:0]    key_r, key_nxt;
  logic        [HANDLE_W-1:0] handle_r, handle_nxt;

  // insertion point lies at or before this cell: empty, or key strictly greater
  assign ins = !valid_r || (key_r > new_word.key);

  // next contents of the cell
  always_comb begin
    valid_nxt  = valid_r;
    key_nxt    = key_r;
    handle_nxt = handle_r;
    if (op.enq) begin
      if (left_ins) begin
        valid_nxt  = left_word.valid;
        key_nxt    = left_word.key;
        handle_nxt = left_word.handle;
      end else if (ins) begin
        valid_nxt  = 1'b1;
        key_nxt    = new_word.key;
        handle_nxt = new_word.handle;
      end
    end else if (op.deq) begin
      valid_nxt  = right_word.valid;
      key_nxt    = right_word.key;
      handle_nxt = right_word.handle;
    end
  end

  // valid bit is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // key and handle need no reset
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
  end

  assign word = '{valid: valid_r, key: key_r, handle: handle_r};

endmodule

### design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in ascending signed key order in a chain of cells.
// ----------------------------------------------------------------------------
// A request is taken at any clock edge with start high; busy is always low, so
// one request per cycle is accepted. Every cell compares its key with the
// incoming key in parallel and shifts or loads in that same cycle, so the
// result word appears with out_valid in the cycle after its request,
// describing the queue after that request. The receiver cannot stall the
// result: it is shown for one cycle only. An enqueue on a full queue is
// dropped and flagged, a dequeue on an empty queue is flagged; front and
// back read as zero when the queue is empty.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [spq_pkg::REQ_W-1:0]            in_req_type,
  input  logic signed [spq_pkg::KEY_W-1:0]     in_ticket,
  input  logic [spq_pkg::HANDLE_W-1:0]         in_payload_handle,
  output logic                                 out_valid,
  output logic signed [spq_pkg::KEY_W-1:0]     out_front_ticket,
  output logic [spq_pkg::HANDLE_W-1:0]         out_front_handle,
  output logic signed [spq_pkg::KEY_W-1:0]     out_back_ticket,
  output logic [spq_pkg::HANDLE_W-1:0]         out_back_handle,
  output logic                                 out_is_empty,
  output logic [spq_pkg::COUNT_OUT_W-1:0]      out_entry_count,
  output logic                                 out_dropped_full,
  output logic                                 out_dequeue_empty
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          accept;
  logic          full, empty;
  op_t           op;
  entry_t        new_word;
  entry_t        cell_q [DEPTH];
  logic          cell_ins [DEPTH];
  logic          is_last [DEPTH];
  entry_t        back_word;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, dropped_r, deq_empty_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  // decode the request into a chain operation
  always_comb begin
    op.enq = 1'b0;
    op.deq = 1'b0;
    if (accept) begin
      case (in_req_type)
        REQ_ENQ: op.enq = !full;
        REQ_DEQ: op.deq = !empty;
        default: ;
      endcase
    end
  end

  assign new_word = '{valid: 1'b1, key: in_ticket, handle: in_payload_handle};

  // the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_w, right_w;
    logic   left_i;
    if (i == 0) begin : g_head
      assign left_w = '0;
      assign left_i = 1'b0;
    end else begin : g_mid
      assign left_w = cell_q[i-1];
      assign left_i = cell_ins[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w    = '0;
      assign is_last[i] = cell_q[i].valid;
    end else begin : g_body
      assign right_w    = cell_q[i+1];
      assign is_last[i] = cell_q[i].valid && !cell_q[i+1].valid;
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .new_word   (new_word),
      .left_word  (left_w),
      .left_ins   (left_i),
      .right_word (right_w),
      .word       (cell_q[i]),
      .ins        (cell_ins[i])
    );
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (op.enq) begin
      count_nxt = count_r + CW'(1);
    end else if (op.deq) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // control and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dropped_r   <= 1'b0;
      deq_empty_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
      dropped_r   <= accept && (in_req_type == REQ_ENQ) && full;
      deq_empty_r <= accept && (in_req_type == REQ_DEQ) && empty;
    end
  end

  // back entry: the one valid cell whose right neighbor is empty
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (is_last[i]) begin
        back_word = back_word | cell_q[i];
      end
    end
  end

  // result word
  assign out_valid         = out_valid_r;
  assign out_front_ticket  = cell_q[0].valid ? cell_q[0].key : '0;
  assign out_front_handle  = cell_q[0].valid ? cell_q[0].handle : '0;
  assign out_back_ticket   = back_word.key;
  assign out_back_handle   = back_word.handle;
  assign out_is_empty      = !cell_q[0].valid;
  assign out_entry_count   = COUNT_OUT_W'(count_r);
  assign out_dropped_full  = dropped_r;
  assign out_dequeue_empty = deq_empty_r;

endmodule

### design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_valid,
  input logic signed [spq_pkg::KEY_W-1:0]     out_front_ticket,
  input logic signed [spq_pkg::KEY_W-1:0]     out_back_ticket,
  input logic                                 out_is_empty,
  input logic [spq_pkg::COUNT_OUT_W-1:0]      out_entry_count,
  input logic                                 out_dropped_full,
  input logic                                 out_dequeue_empty
);
  import spq_pkg::*;

  // every accepted request yields a result word on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted request without a result word");

  // no result word without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result word without a request");

  // a dropped enqueue only happens at full occupancy
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped_full) |->
      (out_entry_count == COUNT_OUT_W'(DEPTH) && !out_is_empty))
    else $error("enqueue dropped below full occupancy");

  // order: front never above back
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_empty) |-> !(out_front_ticket > out_back_ticket))
    else $error("front key above back key");

  // a failed dequeue leaves the queue empty
  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dequeue_empty) |-> (out_is_empty && out_entry_count == '0))
    else $error("dequeue flagged empty on a non-empty queue");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

### test/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Self-checking bench for the sorted priority queue. A queue of requests is
// built up front, with a directed opening and then random fill, drain and mixed
// phases. A driver feeds the requests in with random idle bursts. A monitor
// checks each status word against an in-bench model of the sorted store.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int   DEPTH       = DEPTH_DEF;
  localparam int   RANDOM_REQS = 1950;
  localparam int   QUIET_TAIL  = 150;
  localparam int   STALL_LIMIT = 500;
  localparam int   MAX_REPORTS = 10;
  localparam req_t REQ_STATUS  = 2'd2;
  // unused code, answered like a status request
  localparam req_t REQ_SPARE   = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct {
    req_t                       req;
    logic signed [KEY_W-1:0]    ticket;
    logic        [HANDLE_W-1:0] handle;
    int                         gap;
  } request_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]       front_ticket;
    logic        [HANDLE_W-1:0]    front_handle;
    logic signed [KEY_W-1:0]       back_ticket;
    logic        [HANDLE_W-1:0]    back_handle;
    logic                          is_empty;
    logic        [COUNT_OUT_W-1:0] entry_count;
    logic                          dropped_full;
    logic                          dequeue_empty;
  } status_word_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic [REQ_W-1:0]              in_req_type = '0;
  logic signed [KEY_W-1:0]       in_ticket = '0;
  logic [HANDLE_W-1:0]           in_payload_handle = '0;
  logic                          busy;
  logic                          out_valid;
  logic signed [KEY_W-1:0]       out_front_ticket;
  logic [HANDLE_W-1:0]           out_front_handle;
  logic signed [KEY_W-1:0]       out_back_ticket;
  logic [HANDLE_W-1:0]           out_back_handle;
  logic                          out_is_empty;
  logic [COUNT_OUT_W-1:0]        out_entry_count;
  logic                          out_dropped_full;
  logic                          out_dequeue_empty;

  // model of the sorted store, ascending key order
  logic signed [KEY_W-1:0]       held_key [DEPTH];
  logic        [HANDLE_W-1:0]    held_handle [DEPTH];
  int                            held_count = 0;

  request_t     request_q [$];
  status_word_t pending_status_q [$];
  int           total_words = 0;
  int           accepted_words = 0;
  int           checked_words = 0;
  int           mismatches = 0;
  int           full_drops = 0;
  int           empty_dequeues = 0;
  int           quiet_cycles = 0;

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_ticket         (in_ticket),
    .in_payload_handle (in_payload_handle),
    .out_valid         (out_valid),
    .out_front_ticket  (out_front_ticket),
    .out_front_handle  (out_front_handle),
    .out_back_ticket   (out_back_ticket),
    .out_back_handle   (out_back_handle),
    .out_is_empty      (out_is_empty),
    .out_entry_count   (out_entry_count),
    .out_dropped_full  (out_dropped_full),
    .out_dequeue_empty (out_dequeue_empty)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the model and return the status word it yields
  function automatic status_word_t apply_request(req_t req, logic signed [KEY_W-1:0] key,
                                                 logic [HANDLE_W-1:0] handle);
    status_word_t word;
    int slot;
    word = '0;
    if (req == REQ_ENQ) begin
      if (held_count >= DEPTH) begin
        word.dropped_full = 1'b1;
        full_drops++;
      end else begin
        // insert after every entry with a key less than or equal to the new one
        slot = 0;
        while (slot < held_count && held_key[slot] <= key) slot++;
        for (int i = held_count; i > slot; i--) begin
          held_key[i]    = held_key[i-1];
          held_handle[i] = held_handle[i-1];
        end
        held_key[slot]    = key;
        held_handle[slot] = handle;
        held_count++;
      end
    end else if (req == REQ_DEQ) begin
      if (held_count == 0) begin
        word.dequeue_empty = 1'b1;
        empty_dequeues++;
      end else begin
        for (int i = 1; i < held_count; i++) begin
          held_key[i-1]    = held_key[i];
          held_handle[i-1] = held_handle[i];
        end
        held_count--;
      end
    end
    // front and back read as zero on an empty queue
    if (held_count == 0) begin
      word.is_empty = 1'b1;
    end else begin
      word.front_ticket = held_key[0];
      word.front_handle = held_handle[0];
      word.back_ticket  = held_key[held_count-1];
      word.back_handle  = held_handle[held_count-1];
    end
    word.entry_count = held_count[COUNT_OUT_W-1:0];
    return word;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_ticket();
    int roll;
    roll = $urandom_range(0, 99);
    // narrow range makes equal keys common
    if (roll < 50) return $urandom_range(0, 8) - 4;
    if (roll < 85) return $urandom();
    case ($urandom_range(0, 3))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic queue_request(req_t req, logic signed [KEY_W-1:0] key,
                               logic [HANDLE_W-1:0] handle, int gap);
    request_t item;
    item.req    = req;
    item.ticket = key;
    item.handle = handle;
    item.gap    = gap;
    request_q.push_back(item);
    total_words++;
  endtask

  task automatic compare_field(string name, logic [KEY_W-1:0] exp_val,
                               logic [KEY_W-1:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("word %0d: %s expected %h got %h", checked_words, name, exp_val, act_val);
    end
  endtask

  // driver: one word in flight on the input, idle bursts between words
  always @(posedge clk) begin : drive_words
    logic     took;
    request_t nxt;
    int       hold_off;
    if (!rst_n) begin
      start    <= 1'b0;
      hold_off = 0;
    end else begin
      took = start && !busy;
      if (took) begin
        pending_status_q.push_back(apply_request(in_req_type, in_ticket, in_payload_handle));
        accepted_words++;
      end
      if (start && !took) begin
        // word still waiting, hold it
      end else if (hold_off > 0) begin
        hold_off--;
        start <= 1'b0;
      end else if (request_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        nxt = request_q.pop_front();
        start             <= 1'b1;
        in_req_type       <= nxt.req;
        in_ticket         <= nxt.ticket;
        in_payload_handle <= nxt.handle;
        hold_off          = nxt.gap;
      end
    end
  end

  // monitor: each strobed word against the oldest expectation
  always @(posedge clk) begin : check_words
    status_word_t exp_word;
    if (rst_n && out_valid) begin
      if (pending_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("word %0d: status word with no request outstanding", checked_words);
      end else begin
        exp_word = pending_status_q.pop_front();
        compare_field("front_ticket", exp_word.front_ticket, out_front_ticket);
        compare_field("front_handle", KEY_W'(exp_word.front_handle),
                      KEY_W'(out_front_handle));
        compare_field("back_ticket", exp_word.back_ticket, out_back_ticket);
        compare_field("back_handle", KEY_W'(exp_word.back_handle),
                      KEY_W'(out_back_handle));
        compare_field("is_empty", KEY_W'(exp_word.is_empty), KEY_W'(out_is_empty));
        compare_field("entry_count", KEY_W'(exp_word.entry_count),
                      KEY_W'(out_entry_count));
        compare_field("dropped_full", KEY_W'(exp_word.dropped_full),
                      KEY_W'(out_dropped_full));
        compare_field("dequeue_empty", KEY_W'(exp_word.dequeue_empty),
                      KEY_W'(out_dequeue_empty));
      end
      checked_words++;
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("stalled with %0d of %0d words accepted", accepted_words, total_words);
      $display("sorted_priority_queue_test: errors");
      $finish;
    end
  end

  initial begin
    int   remaining;
    int   phase_len;
    int   roll;
    int   gap;
    bit   calm;
    mix_t mix;
    req_t req;

    // directed opening: empty queue, extremes, equal keys, full queue
    queue_request(REQ_STATUS, '0, '0, 0);
    queue_request(REQ_DEQ, '0, '0, 0);
    queue_request(REQ_ENQ, KEY_MAX, 16'hffff, 0);
    queue_request(REQ_ENQ, KEY_MIN, 16'h0000, 0);
    queue_request(REQ_ENQ, '0, 16'h0001, 0);
    queue_request(REQ_ENQ, '1, 16'h0002, 0);
    queue_request(REQ_ENQ, 32'sd5, 16'h0010, 0);
    queue_request(REQ_ENQ, 32'sd5, 16'h0011, 0);
    queue_request(REQ_ENQ, 32'sd5, 16'h0012, 0);
    queue_request(REQ_SPARE, '1, 16'hffff, 0);
    queue_request(REQ_DEQ, '0, '0, 0);
    queue_request(REQ_ENQ, KEY_MAX, 16'haaaa, 0);
    queue_request(REQ_ENQ, KEY_MIN, 16'h5555, 0);
    for (int i = 0; i < 8; i++)
      queue_request(REQ_ENQ, $urandom(), HANDLE_W'($urandom_range(0, 65535)), 0);
    queue_request(REQ_ENQ, 32'sd7, 16'h1234, 0);
    queue_request(REQ_STATUS, '0, '0, 0);
    queue_request(REQ_DEQ, '0, '0, 0);
    queue_request(REQ_DEQ, '0, '0, 0);

    // random phases biased toward filling, draining or holding steady
    remaining = RANDOM_REQS;
    while (remaining > 0) begin
      phase_len = $urandom_range(12, 60);
      mix       = mix_t'($urandom_range(0, 2));
      calm      = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < phase_len && remaining > 0; n++) begin
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  req = (roll < 80) ? REQ_ENQ : (roll < 92) ? REQ_DEQ : REQ_STATUS;
          MIX_DRAIN: req = (roll < 20) ? REQ_ENQ : (roll < 92) ? REQ_DEQ : REQ_STATUS;
          default:   req = (roll < 45) ? REQ_ENQ : (roll < 90) ? REQ_DEQ : REQ_STATUS;
        endcase
        if (req == REQ_STATUS && $urandom_range(0, 1)) req = REQ_SPARE;
        gap = 0;
        if (!calm && remaining > QUIET_TAIL && $urandom_range(0, 4) == 0)
          gap = $urandom_range(1, 11);
        queue_request(req, pick_ticket(), HANDLE_W'($urandom_range(0, 65535)), gap);
        remaining--;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (accepted_words == total_words);
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d requests checked, %0d status words compared, %0d mismatches",
             accepted_words, checked_words, mismatches);
    $display("%0d enqueues dropped on a full queue, %0d dequeues on an empty one",
             full_drops, empty_dequeues);
    if (mismatches == 0) begin
      $display("sorted_priority_queue_test: clean");
    end else begin
      $display("sorted_priority_queue_test: errors");
    end
    $finish;
  end

endmodule
